/* sv/mbe_pkg.sv */
// shared types, constants and fixed-point helpers for the mandelbrot escape block
package mbe_pkg;

  localparam int LANES = 4;

  localparam logic signed [31:0] RST_REAL_START = -32'sd37748736;
  localparam logic signed [31:0] RST_REAL_STEP  = 32'sd78643;
  localparam logic signed [31:0] RST_IMAG_START = 32'sd18790482;
  localparam logic signed [31:0] RST_IMAG_STEP  = -32'sd78294;

  localparam logic signed [32:0] ESC_LIMIT = 33'sh4000000;

  typedef enum logic [1:0] {
    REG_REAL_START = 2'd0,
    REG_REAL_STEP  = 2'd1,
    REG_IMAG_START = 2'd2,
    REG_IMAG_STEP  = 2'd3
  } mbe_reg_t;

  typedef struct packed {
    logic coord;
    logic csum;
    logic ph0;
    logic eval;
    logic ph1;
    logic ph2;
  } mbe_cmd_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if ((&v[33:31]) || !(|v[33:31])) return v[31:0];
    return v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] qfloor(input logic signed [63:0] p);
    if ((&p[63:55]) || !(|p[63:55])) return p[55:24];
    return p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

/* sv/mbe_lane.sv */
// one escape-time lane: point mapping and the iterated complex squaring
module mbe_lane #(
  parameter int COORD_BITS = 12,
  parameter int CNT_W      = 8,
  parameter int LANE_IDX   = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mbe_pkg::mbe_cmd_t       cmd,
  input  logic [COORD_BITS-1:0]   col,
  input  logic signed [31:0]      real_start,
  input  logic signed [31:0]      real_step,
  input  logic signed [31:0]      cy,
  output logic                    done,
  output logic [CNT_W-1:0]        cnt
);

  localparam int PW = COORD_BITS + 34;
  localparam int SW = COORD_BITS + 35;

  logic [COORD_BITS:0]    idx;
  logic signed [PW-1:0]   prod_nxt;
  logic signed [PW-1:0]   prod_r;
  logic signed [SW-1:0]   csum;
  logic signed [31:0]     cx_nxt;
  logic signed [31:0]     cx_r;
  logic signed [31:0]     x_r;
  logic signed [31:0]     y_r;
  logic signed [31:0]     x2_r;
  logic signed [63:0]     mxy_r;
  logic signed [63:0]     mxx_r;
  logic signed [63:0]     myy_r;
  logic signed [31:0]     y2;
  logic signed [31:0]     qxy;
  logic signed [33:0]     xsum;
  logic signed [33:0]     ysum;
  logic signed [32:0]     mag;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;

  assign idx      = {1'b0, col} + (COORD_BITS + 1)'(LANE_IDX);
  assign prod_nxt = $signed({1'b0, idx}) * real_step;
  assign csum     = SW'(prod_r) + SW'(real_start);
  assign cx_nxt   = ((&csum[SW-1:31]) || !(|csum[SW-1:31])) ? csum[31:0]
                  : (csum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  assign y2   = mbe_pkg::qfloor(myy_r);
  assign qxy  = mbe_pkg::qfloor(mxy_r);
  assign xsum = {{2{x2_r[31]}}, x2_r} - {{2{y2[31]}}, y2} + {{2{cx_r[31]}}, cx_r};
  assign ysum = {qxy[31], qxy, 1'b0} + {{2{cy[31]}}, cy};
  assign mag  = {x2_r[31], x2_r} + {y2[31], y2};

  always_ff @(posedge clk) begin
    if (cmd.coord) begin
      prod_r <= prod_nxt;
      x_r    <= '0;
      y_r    <= '0;
      x2_r   <= '0;
      myy_r  <= '0;
    end
    if (cmd.csum) begin
      cx_r <= cx_nxt;
    end
    if (cmd.ph0) begin
      mxy_r <= x_r * y_r;
      x_r   <= mbe_pkg::sat34(xsum);
    end
    if (cmd.ph1) begin
      y_r   <= mbe_pkg::sat34(ysum);
      mxx_r <= x_r * x_r;
    end
    if (cmd.ph2) begin
      myy_r <= y_r * y_r;
      x2_r  <= mbe_pkg::qfloor(mxx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.coord) begin
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.eval && !done_r) begin
      if (mag > mbe_pkg::ESC_LIMIT) begin
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign done = done_r;
  assign cnt  = cnt_r;

endmodule

/* sv/mbe_merge.sv */
// merging stage: all-lanes-escaped detection and grey colour output register
module mbe_merge #(
  parameter int CNT_W = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   emit,
  input  logic [mbe_pkg::LANES-1:0]              done,
  input  logic [mbe_pkg::LANES-1:0][CNT_W-1:0]   cnt,
  output logic                                   all_done,
  output logic                                   out_valid,
  output logic [mbe_pkg::LANES-1:0][23:0]        colour
);

  logic                                  valid_r;
  logic [mbe_pkg::LANES-1:0][23:0]       colour_r;

  assign all_done = &done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int k = 0; k < mbe_pkg::LANES; k++) begin
        colour_r[k] <= {3{8'(cnt[k])}};
      end
    end
  end

  assign out_valid = valid_r;
  assign colour    = colour_r;

endmodule

/* sv/mandelbrot_escape_lanes.sv */
// top level: register file, iteration sequencer, four lanes and merging stage
//
// usage
//   write real_start, real_step, imag_start, imag_step on the cfg channel
//   (cfg_index 0..3, Q8.24 in cfg_data) while the block is idle; cfg_ready
//   is low while busy. a command transaction takes place at a clock edge
//   with start high and busy low and carries the first column of a group of
//   four pixels and their row.
//   the sequencer forms the points in S_COORD and S_CSUM, then runs S_P0,
//   S_P1 and S_P2 per iteration (one per dependent multiply of the squaring),
//   a final check in S_EVAL and S_EMIT to load the colour register. out_valid
//   is high for exactly one cycle; its transaction is taken once all
//   MAX_ITER iterations have run, or, skipping S_EVAL, once all four lanes
//   have escaped. busy drops in the strobe cycle, so the next command may
//   be taken then.
//   the result cannot be held off by the receiver and is shown only once.
//   reset puts the registers at their defaults, returns the sequencer to
//   idle and clears the strobe.
module mandelbrot_escape_lanes #(
  parameter int MAX_ITER   = 255,
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_BITS-1:0]  in_column,
  input  logic [COORD_BITS-1:0]  in_pixel_row,
  output logic                   out_valid,
  output logic [23:0]            out_colour_lane0,
  output logic [23:0]            out_colour_lane1,
  output logic [23:0]            out_colour_lane2,
  output logic [23:0]            out_colour_lane3,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam int PW    = COORD_BITS + 34;
  localparam int SW    = COORD_BITS + 35;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COORD,
    S_CSUM,
    S_P0,
    S_P1,
    S_P2,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t                                 state_r;
  logic [CNT_W-1:0]                       iter_r;
  logic [COORD_BITS-1:0]                  col_r;
  logic [COORD_BITS-1:0]                  row_r;
  logic signed [PW-1:0]                   cyp_r;
  logic signed [SW-1:0]                   cysum;
  logic signed [31:0]                     cy_r;
  logic signed [31:0]                     real_start_r;
  logic signed [31:0]                     real_step_r;
  logic signed [31:0]                     imag_start_r;
  logic signed [31:0]                     imag_step_r;
  mbe_pkg::mbe_cmd_t                      cmd;
  logic [mbe_pkg::LANES-1:0]              done;
  logic [mbe_pkg::LANES-1:0][CNT_W-1:0]   cnt;
  logic [mbe_pkg::LANES-1:0][23:0]        colour;
  logic                                   all_done;
  logic                                   emit;
  logic                                   accept;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign emit      = (state_r == S_EMIT);

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_start_r <= mbe_pkg::RST_REAL_START;
      real_step_r  <= mbe_pkg::RST_REAL_STEP;
      imag_start_r <= mbe_pkg::RST_IMAG_START;
      imag_step_r  <= mbe_pkg::RST_IMAG_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbe_pkg::REG_REAL_START: real_start_r <= cfg_data;
        mbe_pkg::REG_REAL_STEP:  real_step_r  <= cfg_data;
        mbe_pkg::REG_IMAG_START: imag_start_r <= cfg_data;
        mbe_pkg::REG_IMAG_STEP:  imag_step_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared imaginary coordinate
  assign cysum = SW'(cyp_r) + SW'(imag_start_r);

  always_ff @(posedge clk) begin
    if (state_r == S_COORD) begin
      cyp_r <= $signed({1'b0, row_r}) * imag_step_r;
    end
    if (state_r == S_CSUM) begin
      cy_r <= ((&cysum[SW-1:31]) || !(|cysum[SW-1:31])) ? cysum[31:0]
            : (cysum[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            col_r   <= in_column;
            row_r   <= in_pixel_row;
            state_r <= S_COORD;
          end
        end
        S_COORD: state_r <= S_CSUM;
        S_CSUM: begin
          iter_r  <= '0;
          state_r <= S_P0;
        end
        S_P0: state_r <= S_P1;
        S_P1: begin
          if (all_done) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_P2;
          end
        end
        S_P2: begin
          if (iter_r == CNT_W'(MAX_ITER - 1)) begin
            state_r <= S_EVAL;
          end else begin
            iter_r  <= iter_r + CNT_W'(1);
            state_r <= S_P0;
          end
        end
        S_EVAL: state_r <= S_EMIT;
        S_EMIT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_COORD: cmd.coord = 1'b1;
      S_CSUM:  cmd.csum  = 1'b1;
      S_P0: begin
        cmd.ph0  = 1'b1;
        cmd.eval = (iter_r != '0);
      end
      S_P1:    cmd.ph1   = 1'b1;
      S_P2:    cmd.ph2   = 1'b1;
      S_EVAL:  cmd.eval  = 1'b1;
      default: cmd = '0;
    endcase
  end

  for (genvar k = 0; k < mbe_pkg::LANES; k++) begin : g_lane
    mbe_lane #(
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W),
      .LANE_IDX   (k)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .col        (col_r),
      .real_start (real_start_r),
      .real_step  (real_step_r),
      .cy         (cy_r),
      .done       (done[k]),
      .cnt        (cnt[k])
    );
  end

  mbe_merge #(
    .CNT_W (CNT_W)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .done      (done),
    .cnt       (cnt),
    .all_done  (all_done),
    .out_valid (out_valid),
    .colour    (colour)
  );

  assign out_colour_lane0 = colour[0];
  assign out_colour_lane1 = colour[1];
  assign out_colour_lane2 = colour[2];
  assign out_colour_lane3 = colour[3];

`ifndef NO_ASSERTIONS
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EMIT))
    else $error("result strobe without a preceding emit cycle");

  a_idle_only_via_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(state_r == S_EMIT))
    else $error("sequencer left a group without delivering it");

  a_eval_after_last_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $past(state_r == S_P2 && iter_r == CNT_W'(MAX_ITER - 1)))
    else $error("final check entered before the last iteration");

  a_early_exit_all_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P1 && all_done) |=> (state_r == S_EMIT))
    else $error("early exit missed with all lanes escaped");
`endif

endmodule
